// ===== rtl/rgbsh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbsh_pkg
// Shared types, codes and constants of the RGB sharpen / gray histogram block.
// ----------------------------------------------------------------------------
package rgbsh_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CHAN_W     = 8;
  localparam int BIN_IDX_W  = 3;
  localparam int COUNT_W    = 21;
  localparam int NUM_BINS   = 6;
  localparam int OUT_BINS   = 5;
  localparam int MIN_DIM    = 3;

  localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [BIN_IDX_W-1:0] LAST_BIN  = BIN_IDX_W'(OUT_BINS - 1);

  // gray = (WR*r + WG*g + WB*b + ROUND) / STEP
  localparam int GRAY_SUM_W = 22;
  localparam int GRAY_WR    = 2126;
  localparam int GRAY_WG    = 7152;
  localparam int GRAY_WB    = 722;
  localparam int GRAY_ROUND = 5000;
  localparam int GRAY_STEP  = 510000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_COUNT = 1'b1
  } out_kind_t;

  typedef enum logic [1:0] {
    ITEM_STREAM    = 2'd0,
    ITEM_DRAIN_PIX = 2'd1,
    ITEM_COUNT     = 2'd2
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic                 valid;
    item_t                item;
    logic                 first_col;
    logic                 border;
    pixel_t               below;
    logic [BIN_IDX_W-1:0] bin;
    logic                 last;
  } issue_t;

  typedef struct packed {
    logic   valid;
    pixel_t pix;
  } pix_word_t;

endpackage

// ===== rtl/rgbsh_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbsh_intf
// Valid/ready channels: pixel input, result output and register write port.
// ----------------------------------------------------------------------------
interface rgbsh_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [rgbsh_pkg::CHAN_W-1:0] red_in;
  logic [rgbsh_pkg::CHAN_W-1:0] green_in;
  logic [rgbsh_pkg::CHAN_W-1:0] blue_in;

  modport source (output valid, func, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, func, red_in, green_in, blue_in, output ready);
endinterface

interface rgbsh_out_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [rgbsh_pkg::CHAN_W-1:0]    red_out;
  logic [rgbsh_pkg::CHAN_W-1:0]    green_out;
  logic [rgbsh_pkg::CHAN_W-1:0]    blue_out;
  logic [rgbsh_pkg::BIN_IDX_W-1:0] bin_index;
  logic [rgbsh_pkg::COUNT_W-1:0]   bin_count;
  logic                            last;

  modport source (output valid, kind, red_out, green_out, blue_out, bin_index, bin_count,
                  last, input ready);
  modport sink   (input valid, kind, red_out, green_out, blue_out, bin_index, bin_count,
                  last, output ready);
endinterface

interface rgbsh_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rgbsh_pkg::CFG_IDX_W-1:0]  index;
  logic [rgbsh_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rgbsh_row_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbsh_row_mem
// Two-bank row store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rgbsh_row_mem #(
  parameter int ADDR_W = $clog2(rgbsh_pkg::DEF_MAX_WIDTH) + 1
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr_a,
  input  logic [ADDR_W-1:0]   rd_addr_b,
  output rgbsh_pkg::pixel_t   rd_data_a,
  output rgbsh_pkg::pixel_t   rd_data_b,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  rgbsh_pkg::pixel_t   wr_data
);

  localparam int DEPTH = 1 << ADDR_W;

  rgbsh_pkg::pixel_t mem [DEPTH];
  rgbsh_pkg::pixel_t rd_a_r;
  rgbsh_pkg::pixel_t rd_b_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== rtl/rgbsh_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbsh_ctrl
// Frame position tracking, register port and row store addressing; issues
// at most one word per accepted item into the filter stage.
// ----------------------------------------------------------------------------
module rgbsh_ctrl #(
  parameter  int MAX_WIDTH  = rgbsh_pkg::DEF_MAX_WIDTH,
  parameter  int MAX_HEIGHT = rgbsh_pkg::DEF_MAX_HEIGHT,
  localparam int COL_W      = $clog2(MAX_WIDTH),
  localparam int ADDR_W     = COL_W + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  rgbsh_cfg_if.sink          cfg_ch,
  rgbsh_in_if.sink           in_ch,
  input  logic               adv,
  output rgbsh_pkg::issue_t  issue,
  output logic               rd_en,
  output logic [ADDR_W-1:0]  rd_addr_a,
  output logic [ADDR_W-1:0]  rd_addr_b,
  output logic               wr_en,
  output logic [ADDR_W-1:0]  wr_addr,
  output rgbsh_pkg::pixel_t  wr_data
);

  localparam int W_BITS = $clog2(MAX_WIDTH + 1);
  localparam int H_BITS = $clog2(MAX_HEIGHT + 1);
  localparam int D_BITS = $clog2(MAX_WIDTH + rgbsh_pkg::OUT_BINS);

  logic [W_BITS-1:0] eff_w_r, eff_w_nxt;
  logic [H_BITS-1:0] eff_h_r, eff_h_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [H_BITS-1:0] row_r, row_nxt;
  logic [D_BITS-1:0] drain_r, drain_nxt;
  rgbsh_pkg::issue_t issue_r, issue_nxt;

  logic              acc;
  logic [W_BITS-1:0] col_w;
  logic [W_BITS-1:0] c;
  logic [COL_W-1:0]  c_idx;
  logic [COL_W-1:0]  c_inc;
  logic              first_col;
  logic              last_col;
  logic              bank_cur;
  logic              bank_prev;
  logic [D_BITS-1:0] k_full;
  logic [W_BITS-1:0] w_clamped;
  logic [H_BITS-1:0] h_clamped;

  assign acc          = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !issue_r.valid || adv;
  assign cfg_ch.ready = 1'b1;
  assign issue        = issue_r;
  assign rd_en        = acc;

  assign col_w     = W_BITS'(col_r);
  assign c         = (col_w >= eff_w_r) ? (eff_w_r - W_BITS'(1)) : col_w;
  assign c_idx     = c[COL_W-1:0];
  assign c_inc     = c_idx + COL_W'(1);
  assign first_col = (c == '0);
  assign last_col  = (c == (eff_w_r - W_BITS'(1)));
  assign bank_cur  = row_r[0];
  assign bank_prev = ~row_r[0];
  assign k_full    = drain_r - D_BITS'(eff_w_r);

  always_comb begin
    if (32'(cfg_ch.data) < 32'(rgbsh_pkg::MIN_DIM)) begin
      w_clamped = W_BITS'(rgbsh_pkg::MIN_DIM);
      h_clamped = H_BITS'(rgbsh_pkg::MIN_DIM);
    end else begin
      w_clamped = (32'(cfg_ch.data) > 32'(MAX_WIDTH)) ? W_BITS'(MAX_WIDTH)
                                                       : W_BITS'(cfg_ch.data);
      h_clamped = (32'(cfg_ch.data) > 32'(MAX_HEIGHT)) ? H_BITS'(MAX_HEIGHT)
                                                        : H_BITS'(cfg_ch.data);
    end
  end

  always_comb begin
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    issue_nxt = issue_r;
    rd_addr_a = {bank_prev, first_col ? c_idx : c_inc};
    rd_addr_b = first_col ? {bank_prev, c_inc} : {bank_cur, c_idx};
    wr_en     = 1'b0;
    wr_addr   = {bank_cur, c_idx};
    wr_data   = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};

    if (adv) begin
      issue_nxt.valid = 1'b0;
    end

    if (acc) begin
      issue_nxt       = '0;
      issue_nxt.below = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
      if (in_ch.func == rgbsh_pkg::FUNC_PIXEL) begin
        if (row_r < eff_h_r) begin
          wr_en               = 1'b1;
          issue_nxt.valid     = (row_r != '0);
          issue_nxt.item      = rgbsh_pkg::ITEM_STREAM;
          issue_nxt.first_col = first_col;
          issue_nxt.border    = (row_r == H_BITS'(1)) || first_col || last_col;
          if (last_col) begin
            col_nxt = '0;
            row_nxt = row_r + H_BITS'(1);
          end else begin
            col_nxt = c_inc;
          end
        end
      end else if (row_r >= eff_h_r) begin
        issue_nxt.valid = 1'b1;
        if (drain_r < D_BITS'(eff_w_r)) begin
          rd_addr_a      = {~eff_h_r[0], drain_r[COL_W-1:0]};
          issue_nxt.item = rgbsh_pkg::ITEM_DRAIN_PIX;
          drain_nxt      = drain_r + D_BITS'(1);
        end else begin
          issue_nxt.item = rgbsh_pkg::ITEM_COUNT;
          if (k_full >= D_BITS'(rgbsh_pkg::LAST_BIN)) begin
            issue_nxt.bin  = rgbsh_pkg::LAST_BIN;
            issue_nxt.last = 1'b1;
            col_nxt        = '0;
            row_nxt        = '0;
            drain_nxt      = '0;
          end else begin
            issue_nxt.bin = k_full[rgbsh_pkg::BIN_IDX_W-1:0];
            drain_nxt     = drain_r + D_BITS'(1);
          end
        end
      end
    end

    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rgbsh_pkg::REG_IMAGE_WIDTH: begin
          eff_w_nxt = w_clamped;
          col_nxt   = '0;
          row_nxt   = '0;
          drain_nxt = '0;
        end
        rgbsh_pkg::REG_IMAGE_HEIGHT: begin
          eff_h_nxt = h_clamped;
          col_nxt   = '0;
          row_nxt   = '0;
          drain_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= W_BITS'(rgbsh_pkg::MIN_DIM);
      eff_h_r <= H_BITS'(rgbsh_pkg::MIN_DIM);
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= '0;
      issue_r <= '0;
    end else begin
      eff_w_r <= eff_w_nxt;
      eff_h_r <= eff_h_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      drain_r <= drain_nxt;
      issue_r <= issue_nxt;
    end
  end

endmodule

// ===== rtl/rgbsh_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbsh_filter
// Sliding 3-wide window over the previous row, Laplacian sharpen with clamp,
// and the output register of the result channel.
// ----------------------------------------------------------------------------
module rgbsh_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rgbsh_pkg::issue_t                   issue,
  input  rgbsh_pkg::pixel_t                   rd_a,
  input  rgbsh_pkg::pixel_t                   rd_b,
  input  logic [rgbsh_pkg::COUNT_W-1:0]       count_val,
  input  logic                                hist_busy,
  output logic                                adv,
  output rgbsh_pkg::pix_word_t                pix_load,
  rgbsh_out_if.source                         out_ch
);

  function automatic logic [rgbsh_pkg::CHAN_W-1:0] sharpen(
    input logic [rgbsh_pkg::CHAN_W-1:0] cv,
    input logic [rgbsh_pkg::CHAN_W-1:0] lv,
    input logic [rgbsh_pkg::CHAN_W-1:0] rv,
    input logic [rgbsh_pkg::CHAN_W-1:0] uv,
    input logic [rgbsh_pkg::CHAN_W-1:0] dv
  );
    logic [11:0] pos;
    logic [11:0] neg;
    logic [11:0] diff;
    pos  = 12'(cv) * 12'd5;
    neg  = 12'(lv) + 12'(rv) + 12'(uv) + 12'(dv);
    diff = pos - neg;
    if (neg > pos) begin
      return '0;
    end else if (diff > 12'd255) begin
      return '1;
    end else begin
      return diff[rgbsh_pkg::CHAN_W-1:0];
    end
  endfunction

  rgbsh_pkg::pixel_t win_c_r;
  rgbsh_pkg::pixel_t win_r_r;

  logic                              out_valid_r;
  logic                              kind_r;
  rgbsh_pkg::pixel_t                 pix_r;
  logic [rgbsh_pkg::BIN_IDX_W-1:0]   bin_r;
  logic [rgbsh_pkg::COUNT_W-1:0]     count_r;
  logic                              last_r;

  rgbsh_pkg::pixel_t left;
  rgbsh_pkg::pixel_t centre;
  rgbsh_pkg::pixel_t right;
  rgbsh_pkg::pixel_t up;
  rgbsh_pkg::pixel_t sharp;
  rgbsh_pkg::pixel_t res_pix;
  logic              is_count;

  assign is_count = (issue.item == rgbsh_pkg::ITEM_COUNT);
  assign adv      = issue.valid && (!out_valid_r || out_ch.ready) && !(is_count && hist_busy);

  always_comb begin
    left   = win_c_r;
    centre = win_r_r;
    right  = rd_a;
    up     = rd_b;
    if (issue.first_col) begin
      centre = rd_a;
      right  = rd_b;
    end
    sharp.red   = sharpen(centre.red, left.red, right.red, up.red, issue.below.red);
    sharp.green = sharpen(centre.green, left.green, right.green, up.green,
                          issue.below.green);
    sharp.blue  = sharpen(centre.blue, left.blue, right.blue, up.blue, issue.below.blue);
    case (issue.item)
      rgbsh_pkg::ITEM_STREAM:    res_pix = issue.border ? centre : sharp;
      rgbsh_pkg::ITEM_DRAIN_PIX: res_pix = rd_a;
      default:                   res_pix = '0;
    endcase
  end

  assign pix_load.valid = adv && !is_count;
  assign pix_load.pix   = res_pix;

  always_ff @(posedge clk) begin
    if (adv && (issue.item == rgbsh_pkg::ITEM_STREAM)) begin
      win_c_r <= centre;
      win_r_r <= right;
    end
    if (adv) begin
      kind_r  <= is_count ? rgbsh_pkg::KIND_COUNT : rgbsh_pkg::KIND_PIXEL;
      pix_r   <= res_pix;
      bin_r   <= is_count ? issue.bin : '0;
      count_r <= is_count ? count_val : '0;
      last_r  <= is_count && issue.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = kind_r;
  assign out_ch.red_out   = pix_r.red;
  assign out_ch.green_out = pix_r.green;
  assign out_ch.blue_out  = pix_r.blue;
  assign out_ch.bin_index = bin_r;
  assign out_ch.bin_count = count_r;
  assign out_ch.last      = last_r;

endmodule

// ===== rtl/rgbsh_hist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbsh_hist
// Gray level of each emitted pixel (weighted sum, then threshold compare)
// and six saturating bin counters; serves counts for drain words.
// ----------------------------------------------------------------------------
module rgbsh_hist (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rgbsh_pkg::pix_word_t              pix_in,
  input  logic [rgbsh_pkg::BIN_IDX_W-1:0]   bin_sel,
  output logic [rgbsh_pkg::COUNT_W-1:0]     count_val,
  output logic                              busy
);

  localparam int SW = rgbsh_pkg::GRAY_SUM_W;
  localparam int CW = rgbsh_pkg::COUNT_W;

  logic              gp_v_r;
  rgbsh_pkg::pixel_t gp_pix_r;
  logic              sum_v_r;
  logic [SW-1:0]     sum_r;
  logic [CW-1:0]     bins_r [rgbsh_pkg::NUM_BINS];

  logic [SW-1:0]     sum_nxt;
  logic [SW-1:0]     sum_rnd;
  logic [2:0]        lvl;
  logic [CW:0]       merged;

  assign sum_nxt = SW'(rgbsh_pkg::GRAY_WR) * SW'(gp_pix_r.red)
                 + SW'(rgbsh_pkg::GRAY_WG) * SW'(gp_pix_r.green)
                 + SW'(rgbsh_pkg::GRAY_WB) * SW'(gp_pix_r.blue);
  assign sum_rnd = sum_r + SW'(rgbsh_pkg::GRAY_ROUND);
  assign busy    = gp_v_r || sum_v_r;

  always_comb begin
    lvl = '0;
    for (int k = 1; k < rgbsh_pkg::NUM_BINS; k++) begin
      if (sum_rnd >= SW'(k * rgbsh_pkg::GRAY_STEP)) begin
        lvl = 3'(k);
      end
    end
  end

  always_comb begin
    merged = (CW+1)'(bins_r[rgbsh_pkg::NUM_BINS-2]) + (CW+1)'(bins_r[rgbsh_pkg::NUM_BINS-1]);
    if (bin_sel == rgbsh_pkg::LAST_BIN) begin
      count_val = merged[CW] ? rgbsh_pkg::COUNT_MAX : merged[CW-1:0];
    end else begin
      count_val = bins_r[bin_sel];
    end
  end

  always_ff @(posedge clk) begin
    gp_pix_r <= pix_in.pix;
    sum_r    <= sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_v_r  <= 1'b0;
      sum_v_r <= 1'b0;
      for (int i = 0; i < rgbsh_pkg::NUM_BINS; i++) begin
        bins_r[i] <= '0;
      end
    end else begin
      gp_v_r  <= pix_in.valid;
      sum_v_r <= gp_v_r;
      for (int i = 0; i < rgbsh_pkg::NUM_BINS; i++) begin
        if (sum_v_r && (lvl == 3'(i)) && (bins_r[i] != rgbsh_pkg::COUNT_MAX)) begin
          bins_r[i] <= bins_r[i] + CW'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/rgb_sharpen_with_gray_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_sharpen_with_gray_histogram
// 3x3 Laplacian sharpen of an RGB raster stream with a five-bin gray histogram;
// drain words flush the held last row and then the bin counts.
//
//   channel  dir  word                                             handshake
//   in_ch    in   func, red_in, green_in, blue_in                  valid/ready
//   out_ch   out  kind, rgb_out, bin_index, bin_count, last        valid/ready
//   cfg_ch   in   index (0 width, 1 height), data                  valid/ready
//
// One word per clock while out_ch takes results and no count word waits on the
// histogram; a released result passes the issue register and row store read, then
// the output register. The first count word of a drain waits for the histogram
// pipeline to settle after the last pixel word.
// Reset is synchronous, active low; the row store needs no clearing pass.
// in_ch stalls while the issue word waits: on out_ch, or as a count on hist_busy.
// ----------------------------------------------------------------------------
module rgb_sharpen_with_gray_histogram #(
  parameter int MAX_WIDTH  = rgbsh_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbsh_pkg::DEF_MAX_HEIGHT
) (
  input logic          clk,
  input logic          rst_n,
  rgbsh_cfg_if.sink    cfg_ch,
  rgbsh_in_if.sink     in_ch,
  rgbsh_out_if.source  out_ch
);

  localparam int ADDR_W = $clog2(MAX_WIDTH) + 1;

  rgbsh_pkg::issue_t               issue;
  rgbsh_pkg::pix_word_t            pix_load;
  rgbsh_pkg::pixel_t               rd_a;
  rgbsh_pkg::pixel_t               rd_b;
  rgbsh_pkg::pixel_t               wr_data;
  logic                            adv;
  logic                            rd_en;
  logic                            wr_en;
  logic [ADDR_W-1:0]               rd_addr_a;
  logic [ADDR_W-1:0]               rd_addr_b;
  logic [ADDR_W-1:0]               wr_addr;
  logic [rgbsh_pkg::COUNT_W-1:0]   count_val;
  logic                            hist_busy;

  rgbsh_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ch    (cfg_ch),
    .in_ch     (in_ch),
    .adv       (adv),
    .issue     (issue),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  rgbsh_row_mem #(
    .ADDR_W (ADDR_W)
  ) u_row_mem (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  rgbsh_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .count_val (count_val),
    .hist_busy (hist_busy),
    .adv       (adv),
    .pix_load  (pix_load),
    .out_ch    (out_ch)
  );

  rgbsh_hist u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_in    (pix_load),
    .bin_sel   (issue.bin),
    .count_val (count_val),
    .busy      (hist_busy)
  );

endmodule
